// File: rtl/tcff_pkg.sv
// ============================================================================
// tcff_pkg
// Shared types, constants and helpers of the two-column first-fit tile placer.
// ============================================================================
package tcff_pkg;

    localparam int unsigned TCFF_MAX_ROWS = 256;

    typedef logic [1:0] t_span;
    typedef logic [1:0] t_row;

    localparam t_span SPAN_ONE = 2'd1;
    localparam t_span SPAN_TWO = 2'd2;
    localparam t_row  ROW_FULL = 2'b11;

    typedef struct packed {
        logic              start_new;
        logic signed [7:0] tile_width;
        logic signed [7:0] tile_height;
    } t_tile_req;

    typedef struct packed {
        logic       place_col;
        logic [7:0] place_row;
        logic [1:0] span_width;
        logic [1:0] span_height;
        logic [8:0] rows_used;
        logic       overflow;
    } t_tile_res;

    typedef struct packed {
        logic hit;
        logic col;
    } t_fit;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WR_TOP,
        S_WR_BOT,
        S_DONE
    } t_state;

    function automatic t_span clamp_span(input logic signed [7:0] raw);
        t_span span;
        if (raw[7] || (raw == 8'sd0)) begin
            span = SPAN_ONE;
        end else if (raw > 8'sd2) begin
            span = SPAN_TWO;
        end else begin
            span = raw[1:0];
        end
        return span;
    endfunction

endpackage

// File: rtl/tcff_if.sv
// ============================================================================
// tcff request and result channels
// Valid/ready channels that carry tile requests and placement results.
// ============================================================================
interface tcff_req_if;
    import tcff_pkg::*;

    logic      valid;
    logic      ready;
    t_tile_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcff_res_if;
    import tcff_pkg::*;

    logic      valid;
    logic      ready;
    t_tile_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tcff_fit.sv
// ============================================================================
// tcff_fit
// Picks the leftmost free position for a tile width in one combined row mask.
// ============================================================================
module tcff_fit
    import tcff_pkg::*;
(
    input  t_row  i_occ,
    input  t_span i_span_w,
    output t_fit  o_fit
);

    always_comb begin
        o_fit = '0;
        if (i_span_w == SPAN_TWO) begin
            o_fit.hit = (i_occ == 2'b00);
            o_fit.col = 1'b0;
        end else if (!i_occ[0]) begin
            o_fit.hit = 1'b1;
            o_fit.col = 1'b0;
        end else if (!i_occ[1]) begin
            o_fit.hit = 1'b1;
            o_fit.col = 1'b1;
        end
    end

endmodule

// File: rtl/two_column_first_fit_tile_placer.sv
// ============================================================================
// two_column_first_fit_tile_placer
// First-fit placement of 1..2 by 1..2 tiles on a two-column occupancy grid.
// ============================================================================
// Usage:
//   i_req carries one tile request (start_new, tile_width, tile_height); it is
//   taken when valid and ready are high. o_res carries one placement result
//   per request under the same valid/ready rule, from an output register.
//   Occupancy lives in a MAX_ROWS x 2 bit synchronous RAM. Rows at or beyond
//   the row count read as free, so start_new and reset clear the map at once
//   by zeroing the count; no clearing pass is run.
//   Flow: one row per cycle is scanned. After accept the engine reads row 0,
//   scans the rows in order, writes the top row (two-row tiles only) and
//   the bottom row, then loads the result register; an overflow scan runs
//   to the last row. The single RAM read per cycle sets the scan rate.
//   One request is worked at a time; i_req.ready is high only when idle.
//   A stalled receiver holds the result in the output register; the engine
//   still accepts and scans the next request, and waits in its last step
//   until the register frees.
//   Reset: synchronous, active low; clears the row count and result valid and returns the engine to idle.
// ============================================================================
module two_column_first_fit_tile_placer
    import tcff_pkg::*;
#(
    parameter int unsigned MAX_ROWS = TCFF_MAX_ROWS
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcff_req_if.sink   i_req,
    tcff_res_if.source o_res
);

    localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW = $clog2(MAX_ROWS + 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ROWS - 1);

    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_cur;
    t_row            r_prev;
    t_row            r_q;
    logic [CW-1:0]   r_rc;
    t_span           r_w;
    t_span           r_h;
    logic            r_col;
    logic            r_ovf;
    t_row            r_new_top;
    t_row            r_new_bot;
    t_row            r_mem [MAX_ROWS];
    logic            r_out_valid;
    t_tile_res       r_out;

    logic            req_acc;
    logic            tall;
    t_row            eff_cur;
    t_row            chk;
    t_row            cmask;
    t_fit            fit;
    logic            at_end;
    logic            scan_hit;
    logic            scan_step;
    logic            scan_miss;
    logic [CW-1:0]   bottom_ext;
    logic [AW-1:0]   top_row;
    logic            out_free;
    logic            out_load;
    logic            in_ready;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    t_row            wr_data;
    t_tile_res       res;

    function automatic t_row r_col_sel(input logic col);
        return col ? 2'b10 : 2'b01;
    endfunction

    assign req_acc    = i_req.valid && in_ready;
    assign tall       = (r_h == SPAN_TWO);
    assign eff_cur    = (CW'(r_cur) < r_rc) ? r_q : 2'b00;
    assign chk        = tall ? (r_prev | eff_cur) : eff_cur;
    assign cmask      = (r_w == SPAN_TWO) ? ROW_FULL : (r_col_sel(fit.col));
    assign at_end     = (r_cur == LAST_ROW);
    assign scan_hit   = (r_state == S_SCAN) && fit.hit;
    assign scan_step  = (r_state == S_SCAN) && !fit.hit && !at_end;
    assign scan_miss  = (r_state == S_SCAN) && !fit.hit && at_end;
    assign bottom_ext = CW'(r_cur) + CW'(1);
    assign top_row    = tall ? (r_cur - AW'(1)) : r_cur;
    assign out_free   = !r_out_valid || o_res.ready;

    tcff_fit u_fit (
        .i_occ    (chk),
        .i_span_w (r_w),
        .o_fit    (fit)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (fit.hit) begin
                    n_state = tall ? S_WR_TOP : S_WR_BOT;
                end else if (at_end) begin
                    n_state = S_DONE;
                end
            end
            S_WR_TOP: begin
                n_state = S_WR_BOT;
            end
            S_WR_BOT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_addr  = '0;
        mem_we   = 1'b0;
        wr_addr  = r_cur;
        wr_data  = r_new_bot;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_LOAD: begin
                rd_addr = '0;
            end
            S_SCAN: begin
                rd_addr = r_cur + AW'(1);
            end
            S_WR_TOP: begin
                mem_we  = 1'b1;
                wr_addr = r_cur - AW'(1);
                wr_data = r_new_top;
            end
            S_WR_BOT: begin
                mem_we  = 1'b1;
                wr_addr = r_cur;
                wr_data = r_new_bot;
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        res             = '0;
        res.place_col   = r_ovf ? 1'b0 : r_col;
        res.place_row   = r_ovf ? 8'd0 : 8'(top_row);
        res.span_width  = r_w;
        res.span_height = r_h;
        res.rows_used   = 9'(r_rc);
        res.overflow    = r_ovf;
    end

    assign i_req.ready   = in_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_acc && i_req.payload.start_new) begin
                r_rc <= '0;
            end else if (scan_hit && (bottom_ext > r_rc)) begin
                r_rc <= bottom_ext;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_w    <= clamp_span(i_req.payload.tile_width);
            r_h    <= clamp_span(i_req.payload.tile_height);
            r_cur  <= '0;
            r_prev <= ROW_FULL;
            r_ovf  <= 1'b0;
        end
        if (scan_step) begin
            r_cur  <= r_cur + AW'(1);
            r_prev <= eff_cur;
        end
        if (scan_hit) begin
            r_col     <= fit.col;
            r_new_top <= r_prev | cmask;
            r_new_bot <= eff_cur | cmask;
        end
        if (scan_miss) begin
            r_ovf <= 1'b1;
        end
        if (out_load) begin
            r_out <= res;
        end
    end

endmodule

// File: rtl/tcff_checker.sv
// ============================================================================
// tcff_checker
// Port-level checks of the tile placer, bound to the top level.
// ============================================================================
module tcff_checker
    import tcff_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_tile_res i_out
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("stalled result changed");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out.span_width == SPAN_ONE || i_out.span_width == SPAN_TWO)
                     && (i_out.span_height == SPAN_ONE || i_out.span_height == SPAN_TWO))
        else $error("span out of range");

    a_overflow_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.overflow |-> !i_out.place_col && (i_out.place_row == 8'd0))
        else $error("overflow result not at origin");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

endmodule

bind two_column_first_fit_tile_placer tcff_checker u_tcff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out       (o_res.payload)
);
